@@ rtl/core/key_matrix_debouncer_assert.svh @@
// Assertion macros for the debouncer RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef KEY_MATRIX_DEBOUNCER_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmd assertion failed");

`endif

@@ rtl/core/kmd_pkg.sv @@
package kmd_pkg;

  localparam int KEY_BITS = 16;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 20;
  localparam int POS_W    = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 20'd5000;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_TAKE = 1'b1
  } kmd_op_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] stable_keys;
    logic [KEY_BITS-1:0] pending_keys;
    logic                event_valid;
    logic [POS_W-1:0]    event_row;
    logic [POS_W-1:0]    event_column;
  } kmd_result_t;

endpackage

@@ rtl/core/kmd_if.sv @@
interface kmd_in_if;
  import kmd_pkg::*;
  logic                valid;
  logic                ready;
  logic                operation;
  logic [KEY_BITS-1:0] scanned_keys;
  logic [TIME_W-1:0]   time_us;
  modport source (output valid, operation, scanned_keys, time_us, input ready);
  modport sink (input valid, operation, scanned_keys, time_us, output ready);
endinterface

interface kmd_out_if;
  import kmd_pkg::*;
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] stable_keys;
  logic [KEY_BITS-1:0] pending_keys;
  logic                event_valid;
  logic [POS_W-1:0]    event_row;
  logic [POS_W-1:0]    event_column;
  modport source (output valid, stable_keys, pending_keys, event_valid, event_row,
                  event_column, input ready);
  modport sink (input valid, stable_keys, pending_keys, event_valid, event_row,
                event_column, output ready);
endinterface

interface kmd_cfg_if;
  import kmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEB_W-1:0] debounce_us;
  modport source (output valid, debounce_us, input ready);
  modport sink (input valid, debounce_us, output ready);
endinterface

@@ rtl/core/kmd_lane.sv @@
module kmd_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        scan_en,
  input  logic                        sample,
  input  logic [kmd_pkg::TIME_W-1:0]  now,
  input  logic [kmd_pkg::DEB_W-1:0]   debounce_us,
  output logic                        stable_nxt,
  output logic                        press
);
  import kmd_pkg::*;

  logic              raw_r, raw_nxt;
  logic              stable_r;
  logic [TIME_W-1:0] change_time_r, change_time_nxt;
  logic [TIME_W-1:0] elapsed;

  assign elapsed = now - change_time_r;

  // A raw edge restarts the hold timer; a level that held long enough
  // moves the debounced bit.
  always_comb begin
    raw_nxt         = raw_r;
    stable_nxt      = stable_r;
    change_time_nxt = change_time_r;
    press           = 1'b0;
    if (scan_en) begin
      if (sample != raw_r) begin
        raw_nxt         = sample;
        change_time_nxt = now;
      end else if ((sample != stable_r) &&
                   (elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_us})) begin
        stable_nxt = sample;
        press      = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r         <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
    end else begin
      raw_r         <= raw_nxt;
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
    end
  end

endmodule

@@ rtl/core/kmd_merge.sv @@
module kmd_merge #(
  parameter int KEY_COUNT = 16,
  parameter int COLUMNS   = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take_en,
  input  logic [kmd_pkg::KEY_BITS-1:0]  stable_nxt,
  input  logic [kmd_pkg::KEY_BITS-1:0]  press,
  output kmd_pkg::kmd_result_t          result
);
  import kmd_pkg::*;

  logic [KEY_BITS-1:0] pending_r, pending_nxt;
  logic [KEY_BITS-1:0] lowest;
  logic                found;
  logic [POS_W-1:0]    row;
  logic [POS_W-1:0]    column;

  // Isolate the lowest pending key as a one-hot mask.
  assign lowest = pending_r & (~pending_r + KEY_BITS'(1));
  assign found  = |pending_r;

  always_comb begin
    row    = '0;
    column = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (lowest[k]) begin
        row    = POS_W'(k / COLUMNS);
        column = POS_W'(k % COLUMNS);
      end
    end
  end

  always_comb begin
    pending_nxt         = pending_r | press;
    result.event_valid  = 1'b0;
    result.event_row    = '0;
    result.event_column = '0;
    if (take_en && found) begin
      pending_nxt         = pending_r & ~lowest;
      result.event_valid  = 1'b1;
      result.event_row    = row;
      result.event_column = column;
    end
    result.stable_keys  = stable_nxt;
    result.pending_keys = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ rtl/core/kmd_skid.sv @@
`include "key_matrix_debouncer_assert.svh"

module kmd_skid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  kmd_pkg::kmd_result_t  push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kmd_pkg::kmd_result_t  out_data
);
  import kmd_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  kmd_result_t out_data_r, out_data_nxt;
  kmd_result_t skid_data_r, skid_data_nxt;

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (push) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `KMD_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `KMD_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, push && out_valid_r && !out_ready,
                   skid_valid_r && out_valid_r)
  `KMD_ASSERT_NEXT(a_skid_drains, clk, rst_n, out_valid_r && out_ready && skid_valid_r,
                   out_valid_r && !skid_valid_r)

endmodule

@@ rtl/core/key_matrix_debouncer.sv @@
// Key matrix debouncer with a press-event queue.
// in_ch carries one item per handshake: operation selects a scan (one sampled
// bit per key plus a wrapping microsecond timestamp) or a take, which pops the
// lowest-numbered pending press and reports its row and column.
// out_ch returns exactly one item per accepted input item, in order: the
// debounced and pending key bits after that item, plus the taken event.
// cfg_ch writes debounce_us; it is always ready and should only be used while
// no items are in flight.
// Each result is registered in the output stage, or in the skid stage while
// the receiver stalls. Throughput is one item per cycle while the skid stage is
// empty; each tracked key has a lane with a 32-bit subtract and compare, and a
// single priority encoder picks events. Reset clears all key state, the pending
// bits and the output-stage valid flags, and loads debounce_us with 5000.
// When the receiver stalls, one further item is held in a skid stage, and
// in_ch.ready drops only once both output slots are full.
module key_matrix_debouncer #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  kmd_in_if.sink     in_ch,
  kmd_out_if.source  out_ch,
  kmd_cfg_if.sink    cfg_ch
);
  import kmd_pkg::*;

  // Only the first sixteen keys of a large matrix are tracked.
  localparam int KEY_COUNT = (ROWS * COLUMNS > KEY_BITS) ? KEY_BITS : ROWS * COLUMNS;

  logic             accept;
  logic             scan_en;
  logic             take_en;
  logic             can_push;
  logic [DEB_W-1:0] debounce_r;

  logic [KEY_BITS-1:0] stable_nxt;
  logic [KEY_BITS-1:0] press;
  kmd_result_t         result;
  kmd_result_t         out_data;

  assign accept   = in_ch.valid && in_ch.ready;
  assign scan_en  = accept && (kmd_op_t'(in_ch.operation) == OP_SCAN);
  assign take_en  = accept && (kmd_op_t'(in_ch.operation) == OP_TAKE);
  assign in_ch.ready = can_push;

  // The debounce register accepts a write in every cycle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_ch.valid) begin
      debounce_r <= cfg_ch.debounce_us;
    end
  end

  // One lane per existing key; absent keys read as released with no events.
  for (genvar k = 0; k < KEY_BITS; k++) begin : g_key
    if (k < KEY_COUNT) begin : g_lane
      kmd_lane u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan_en     (scan_en),
        .sample      (in_ch.scanned_keys[k]),
        .now         (in_ch.time_us),
        .debounce_us (debounce_r),
        .stable_nxt  (stable_nxt[k]),
        .press       (press[k])
      );
    end else begin : g_absent
      assign stable_nxt[k] = 1'b0;
      assign press[k]      = 1'b0;
    end
  end

  // The merge stage owns the pending bits and picks the event to report.
  kmd_merge #(
    .KEY_COUNT (KEY_COUNT),
    .COLUMNS   (COLUMNS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .take_en    (take_en),
    .stable_nxt (stable_nxt),
    .press      (press),
    .result     (result)
  );

  // Output register plus skid slot so a stalled receiver stops intake only once the skid slot is full.
  kmd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.stable_keys  = out_data.stable_keys;
  assign out_ch.pending_keys = out_data.pending_keys;
  assign out_ch.event_valid  = out_data.event_valid;
  assign out_ch.event_row    = out_data.event_row;
  assign out_ch.event_column = out_data.event_column;

endmodule
